### hw/rtl/chtab_pkg.sv
`timescale 1ns / 1ps

package chtab_pkg;

  localparam int NUM_BUCKETS  = 91;
  localparam int BUCKET_DEPTH = 8;
  localparam int TOTAL_SLOTS  = NUM_BUCKETS * BUCKET_DEPTH;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int SLOT_W  = $clog2(TOTAL_SLOTS);
  localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int IDX_W   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;

  localparam int RDX_BITS  = 8;
  localparam int MOD_STEPS = KEY_W / RDX_BITS;
  localparam int CNT_W     = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int MOD_W     = BKT_W + RDX_BITS;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_FILL,
    S_SEARCH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic search_start;
    logic search_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mod_last;
    logic search_done;
    logic out_free;
  } dp_sts_t;

endpackage

### hw/rtl/chtab_ram.sv
`timescale 1ns / 1ps

module chtab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/chtab_ctrl.sv
`timescale 1ns / 1ps

module chtab_ctrl
  import chtab_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_MOD;
      end
      S_MOD: begin
        if (sts.mod_last) state_next = S_FILL;
      end
      S_FILL: begin
        state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (sts.search_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MOD:    cmd.mod_step     = 1'b1;
      S_FILL:   cmd.search_start = 1'b1;
      S_SEARCH: cmd.search_step  = 1'b1;
      S_FINISH: cmd.finish       = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/chtab_dp.sv
`timescale 1ns / 1ps

module chtab_dp
  import chtab_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd,
  output dp_sts_t          sts,
  input  logic             operation,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic             found,
  output logic [VAL_W-1:0] value_out
);

  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [KEY_W-1:0]  mod_sh;
  logic [BKT_W-1:0]  bucket;
  logic [BKT_W-1:0]  bucket_next;
  logic [CNT_W-1:0]  mod_cnt;
  logic [FILL_W-1:0] rd_idx;
  logic              cmp_pend;
  logic              hit_q;
  logic [VAL_W-1:0]  hit_val;
  logic [NUM_BUCKETS-1:0] fill_vld;

  logic [FILL_W-1:0] fill_rdata;
  logic [FILL_W-1:0] fill_eff;
  logic [KEY_W-1:0]  key_rdata;
  logic [VAL_W-1:0]  val_rdata;
  logic [SLOT_W-1:0] base;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] wr_slot;
  logic              issue;
  logic              match;
  logic              full;
  logic              ins_ok;
  logic              wr_en;
  status_t           res_status;
  logic              res_found;
  logic [VAL_W-1:0]  res_value;

  // Reduce one byte of the key per cycle, most significant first.
  always_comb begin
    logic [MOD_W-1:0] t;
    t = {bucket, mod_sh[KEY_W-1 -: RDX_BITS]};
    for (int k = RDX_BITS - 1; k >= 0; k--) begin
      if (t >= (MOD_W'(NUM_BUCKETS) << k)) begin
        t = t - (MOD_W'(NUM_BUCKETS) << k);
      end
    end
    bucket_next = t[BKT_W-1:0];
  end

  assign fill_eff = fill_vld[bucket] ? fill_rdata : '0;
  assign base     = SLOT_W'(bucket) * SLOT_W'(BUCKET_DEPTH);
  assign rd_slot  = base + SLOT_W'(rd_idx[IDX_W-1:0]);
  assign wr_slot  = base + SLOT_W'(fill_eff[IDX_W-1:0]);
  assign issue    = rd_idx < fill_eff;
  assign match    = cmp_pend && (key_rdata == key_q);
  assign full     = fill_eff >= FILL_W'(BUCKET_DEPTH);
  assign ins_ok   = (op_q == OP_INSERT) && !hit_q && !full;
  assign wr_en    = cmd.finish && ins_ok;

  assign sts.mod_last    = mod_cnt == CNT_W'(MOD_STEPS - 1);
  assign sts.search_done = match || (!cmp_pend && !issue);
  assign sts.out_free    = !out_valid || out_ready;

  always_comb begin
    res_found = hit_q;
    res_value = '0;
    if (op_q == OP_INSERT) begin
      if (hit_q) begin
        res_status = ST_DUPLICATE;
      end else if (full) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_OK;
      end
    end else begin
      if (hit_q) begin
        res_status = ST_OK;
        res_value  = hit_val;
      end else begin
        res_status = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      key_q   <= key;
      val_q   <= value;
      mod_sh  <= key;
      bucket  <= '0;
      mod_cnt <= '0;
    end
    if (cmd.mod_step) begin
      bucket  <= bucket_next;
      mod_sh  <= mod_sh << RDX_BITS;
      mod_cnt <= mod_cnt + 1'b1;
    end
    if (cmd.search_start) begin
      rd_idx   <= '0;
      cmp_pend <= 1'b0;
      hit_q    <= 1'b0;
    end
    if (cmd.search_step) begin
      if (issue) rd_idx <= rd_idx + 1'b1;
      cmp_pend <= issue;
      if (match) begin
        hit_q   <= 1'b1;
        hit_val <= val_rdata;
      end
    end
    if (cmd.finish) begin
      status    <= res_status;
      found     <= res_found;
      value_out <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      fill_vld  <= '0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) fill_vld[bucket] <= 1'b1;
    end
  end

  chtab_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_BUCKETS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (bucket),
    .wdata (fill_eff + 1'b1),
    .raddr (bucket),
    .rdata (fill_rdata)
  );

  chtab_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TOTAL_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_slot),
    .wdata (key_q),
    .raddr (rd_slot),
    .rdata (key_rdata)
  );

  chtab_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TOTAL_SLOTS)
  ) u_val_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_slot),
    .wdata (val_q),
    .raddr (rd_slot),
    .rdata (val_rdata)
  );

endmodule

### hw/rtl/chained_hash_table_top.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    operation, key, value
// output    out_valid / out_ready  status, found, value_out
//
// A transaction reduces the key to its bucket a byte at a time (S_MOD), reads
// the bucket's fill count (S_FILL), reads the key RAM one slot a cycle over the
// n entries searched in the bucket (0 to 8), then writes back and loads the
// output register in S_FINISH, which waits until the output is free.
// Reset clears the fill counts through per-bucket valid bits; no clearing pass.
// A stalled output holds the result; the next transaction is taken meanwhile.

module chained_hash_table_top
  import chtab_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             operation,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic             found,
  output logic [VAL_W-1:0] value_out
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  chtab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  chtab_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .operation (operation),
    .key       (key),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .found     (found),
    .value_out (value_out)
  );

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == ST_OK || status == ST_DUPLICATE))
    else $error("found flag with a miss or full status");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (value_out == '0))
    else $error("nonzero value without a hit");

endmodule
